// File: rtl/rsps_pkg.sv
// Shared types, constants and tables for the radar sweep pixel shader.
package rsps_pkg;

  localparam int DEF_SCREEN_WIDTH  = 120;
  localparam int DEF_SCREEN_HEIGHT = 60;
  localparam int DEF_SWEEP_STEP    = 209;
  localparam int DEF_ANGLE_BITS    = 16;

  localparam int NUM_BLIPS   = 4;
  localparam int NUM_REGS    = 2 * NUM_BLIPS;
  localparam int LANES       = NUM_BLIPS + 1;
  localparam int CORDIC_STEPS = 24;
  localparam int CW          = 32;
  localparam int ZW          = 34;
  localparam int SCALE_SHIFT = 20;

  localparam logic [NUM_REGS-1:0][7:0] BLIP_INIT = {
    8'd12, 8'hE4, 8'hF0, 8'd6, 8'd10, 8'd24, 8'hF8, 8'hEC
  };

  localparam logic [CORDIC_STEPS-1:0][31:0] ARC_TABLE = {
    32'd81, 32'd163, 32'd326, 32'd652, 32'd1304, 32'd2608,
    32'd5215, 32'd10430, 32'd20861, 32'd41722, 32'd83443, 32'd166886,
    32'd333772, 32'd667544, 32'd1335087, 32'd2670163, 32'd5340245, 32'd10679838,
    32'd21354465, 32'd42667331, 32'd85004756, 32'd167458907, 32'd316933406,
    32'd536870912
  };

  localparam logic [17:0] DISC_LIMIT = 18'd784;
  localparam logic [17:0] RING0_LO = 18'd74;
  localparam logic [17:0] RING0_HI = 18'd88;
  localparam logic [17:0] RING1_LO = 18'd310;
  localparam logic [17:0] RING1_HI = 18'd338;
  localparam logic [17:0] RING2_LO = 18'd708;
  localparam logic [17:0] RING2_HI = 18'd750;

  localparam logic [7:0] GREEN_BASE  = 8'd14;
  localparam logic [7:0] BLUE_BASE   = 8'd22;
  localparam logic [7:0] ALPHA       = 8'd255;
  localparam logic [7:0] RED         = 8'd10;
  localparam logic [7:0] RING_GREEN  = 8'd15;
  localparam logic [7:0] RING_BLUE   = 8'd25;
  localparam logic [7:0] CROSS_GREEN = 8'd10;
  localparam logic [7:0] CROSS_BLUE  = 8'd20;
  localparam logic [7:0] STALE_GREEN = 8'd20;
  localparam logic [7:0] STALE_BLUE  = 8'd30;
  localparam logic [31:0] SWEEP_W_GREEN = 32'd40;
  localparam logic [31:0] SWEEP_W_BLUE  = 32'd65;
  localparam logic [31:0] BLIP_W_GREEN  = 32'd160;
  localparam logic [31:0] BLIP_W_BLUE   = 32'd200;

  typedef struct packed {
    logic xneg;
    logic yneg;
    logic xzero;
    logic yzero;
  } axis_t;

  typedef struct packed {
    logic                 in_disc;
    logic                 ring;
    logic                 on_axis;
    logic [NUM_BLIPS-1:0] hit;
    logic                 last;
  } side_t;

endpackage

// File: rtl/rsps_cell.sv
// One CORDIC vectoring cell: a single rotation step for one vector.
module rsps_cell #(
  parameter int STEP = 0
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [rsps_pkg::CW-1:0] x_in,
  input  logic signed [rsps_pkg::CW-1:0] y_in,
  input  logic signed [rsps_pkg::ZW-1:0] z_in,
  output logic signed [rsps_pkg::CW-1:0] x_out,
  output logic signed [rsps_pkg::CW-1:0] y_out,
  output logic signed [rsps_pkg::ZW-1:0] z_out
);
  import rsps_pkg::*;

  localparam logic signed [ZW-1:0] ARC = signed'(ZW'(ARC_TABLE[STEP]));

  logic signed [CW-1:0] sx;
  logic signed [CW-1:0] sy;

  assign sx = x_in >>> STEP;
  assign sy = y_in >>> STEP;

  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_in[CW-1]) begin
        x_out <= x_in + sy;
        y_out <= y_in - sx;
        z_out <= z_in + ARC;
      end else begin
        x_out <= x_in - sy;
        y_out <= y_in + sx;
        z_out <= z_in - ARC;
      end
    end
  end

endmodule

// File: rtl/rsps_shade.sv
// Angle finish, sweep lag, fades and color sum: the last two pipeline stages.
module rsps_shade #(
  parameter int ANGLE_BITS = rsps_pkg::DEF_ANGLE_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   valid_in,
  input  rsps_pkg::side_t                        side_in,
  input  logic [ANGLE_BITS-1:0]                  sweep_in,
  input  logic signed [rsps_pkg::ZW-1:0]         z_in [rsps_pkg::LANES],
  input  rsps_pkg::axis_t                        axis_in [rsps_pkg::LANES],
  output logic                                   valid_out,
  output logic [31:0]                            pixel_word,
  output logic                                   last_out
);
  import rsps_pkg::*;

  localparam int AB = ANGLE_BITS;
  localparam int AW = AB + 3;
  localparam int TURN = 1 << AB;
  localparam int HALF = TURN >> 1;
  localparam int QUART = TURN >> 2;
  localparam logic [31:0] ROUND = 32'd1 << (31 - AB);
  localparam logic signed [ZW-1:0] ZMAX = signed'(ZW'(64'd1 << 30));

  logic [AB:0]  lag_c [LANES];
  logic [AB:0]  lag   [LANES];
  side_t        side_a;
  logic         valid_a;

  always_comb begin
    logic [31:0]          zc;
    logic [31:0]          qr;
    logic signed [AW-1:0] q;
    logic signed [AW-1:0] t;
    logic signed [AW-1:0] ang;
    logic signed [AW-1:0] d;
    for (int l = 0; l < LANES; l++) begin
      if (z_in[l][ZW-1]) begin
        zc = '0;
      end else if (z_in[l] > ZMAX) begin
        zc = 32'h4000_0000;
      end else begin
        zc = z_in[l][31:0];
      end
      qr = (zc + ROUND) >> (32 - AB);
      q = signed'(AW'(qr[AB-1:0]));
      t = axis_in[l].xneg ? AW'(HALF) - q : q;
      if (axis_in[l].yzero) begin
        ang = axis_in[l].xneg ? AW'(HALF) : '0;
      end else if (axis_in[l].xzero) begin
        ang = axis_in[l].yneg ? -AW'(QUART) : AW'(QUART);
      end else begin
        ang = axis_in[l].yneg ? -t : t;
      end
      d = signed'(AW'(sweep_in)) - ang;
      if (d[AW-1]) begin
        d = d + AW'(TURN);
      end
      lag_c[l] = d[AB:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lag    <= lag_c;
      side_a <= side_in;
    end
  end

  logic [7:0] green_c;
  logic [7:0] blue_c;

  always_comb begin
    logic [31:0] span;
    green_c = GREEN_BASE;
    blue_c  = BLUE_BASE;
    span    = '0;
    if (side_a.in_disc) begin
      if (side_a.ring) begin
        green_c = green_c + RING_GREEN;
        blue_c  = blue_c + RING_BLUE;
      end
      if (side_a.on_axis) begin
        green_c = green_c + CROSS_GREEN;
        blue_c  = blue_c + CROSS_BLUE;
      end
      if (lag[0] < (AB+1)'(QUART)) begin
        span = 32'(QUART) - 32'(lag[0]);
        green_c = green_c + 8'((SWEEP_W_GREEN * span) >> (AB - 2));
        blue_c  = blue_c + 8'((SWEEP_W_BLUE * span) >> (AB - 2));
      end
    end
    for (int k = 0; k < NUM_BLIPS; k++) begin
      span = 32'(HALF) - 32'(lag[k+1]);
      if (side_a.hit[k]) begin
        if (lag[k+1] < (AB+1)'(HALF)) begin
          green_c = green_c + 8'((BLIP_W_GREEN * span) >> (AB - 1));
          blue_c  = blue_c + 8'((BLIP_W_BLUE * span) >> (AB - 1));
        end else begin
          green_c = green_c + STALE_GREEN;
          blue_c  = blue_c + STALE_BLUE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      valid_out <= 1'b0;
    end else if (en) begin
      valid_a   <= valid_in;
      valid_out <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pixel_word <= {ALPHA, blue_c, green_c, RED};
      last_out   <= side_a.last;
    end
  end

endmodule

// File: rtl/radar_sweep_pixel_shader.sv
// Radar display pixel shader: entry stage, CORDIC cell chain and color stages.
// A pixel passes the entry stage, the fully pipelined 24-cell CORDIC chain and the color stages.
// Throughput: one pixel per cycle unless the output stalls; the CORDIC chain is five lanes wide.
// The whole pipeline advances whenever the output register is empty or taken.
// Reset clears the valid bits, the sweep angle and loads the default target offsets.
module radar_sweep_pixel_shader #(
  parameter int SCREEN_WIDTH  = rsps_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = rsps_pkg::DEF_SCREEN_HEIGHT,
  parameter int SWEEP_STEP    = rsps_pkg::DEF_SWEEP_STEP,
  parameter int ANGLE_BITS    = rsps_pkg::DEF_ANGLE_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // pixel_col[6:0], pixel_row[12:7], zero fill
  input  logic        s_tlast,   // frame_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // pixel_word[31:0]
  output logic        m_tlast,   // last_of_frame
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import rsps_pkg::*;

  localparam int AB = ANGLE_BITS;
  localparam logic [8:0] CX = 9'(SCREEN_WIDTH / 2);
  localparam logic [8:0] CY = 9'(SCREEN_HEIGHT / 2);
  localparam logic [AB-1:0] STEP = AB'(SWEEP_STEP);

  logic                en;
  logic [AB-1:0]       sweep;
  logic [7:0]          blip_reg [NUM_REGS];

  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        blip_reg[i] <= BLIP_INIT[i];
      end
    end else if (cfg_valid && cfg_index < 4'(NUM_REGS)) begin
      blip_reg[cfg_index[2:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
    end else if (s_tvalid && s_tready && s_tlast) begin
      sweep <= sweep + STEP;
    end
  end

  logic signed [8:0]  dx;
  logic signed [8:0]  dy;
  logic [17:0]        d2;
  logic signed [8:0]  vx [LANES];
  logic signed [8:0]  vy [LANES];
  side_t              side_c;

  assign dx = signed'({2'b00, s_tdata[6:0]} - CX);
  assign dy = signed'({3'b000, s_tdata[12:7]} - CY);

  always_comb begin
    logic signed [17:0] sqx;
    logic signed [17:0] sqy;
    logic signed [9:0]  ex;
    logic signed [9:0]  ey;
    sqx = dx * dx;
    sqy = dy * dy;
    d2  = 18'(sqx) + 18'(sqy);
    side_c.in_disc = d2 < DISC_LIMIT;
    side_c.ring = (d2 >= RING0_LO && d2 <= RING0_HI) ||
                  (d2 >= RING1_LO && d2 <= RING1_HI) ||
                  (d2 >= RING2_LO && d2 <= RING2_HI);
    side_c.on_axis = (dx == '0) || (dy == '0);
    side_c.last = s_tlast;
    vx[0] = dx;
    vy[0] = dy;
    for (int k = 0; k < NUM_BLIPS; k++) begin
      vx[k+1] = signed'({blip_reg[2*k][7], blip_reg[2*k]});
      vy[k+1] = signed'({blip_reg[2*k+1][7], blip_reg[2*k+1]});
      ex = {dx[8], dx} - {{2{blip_reg[2*k][7]}}, blip_reg[2*k]};
      ey = {dy[8], dy} - {{2{blip_reg[2*k+1][7]}}, blip_reg[2*k+1]};
      side_c.hit[k] = (ex == 10'sd0 && (ey == 10'sd0 || ey == 10'sd1 || ey == -10'sd1)) ||
                      (ey == 10'sd0 && (ex == 10'sd1 || ex == -10'sd1));
    end
  end

  logic                  v0;
  side_t                 side0;
  logic [AB-1:0]         sweep0;
  axis_t                 axis0 [LANES];
  logic signed [CW-1:0]  x0 [LANES];
  logic signed [CW-1:0]  y0 [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    logic [8:0] ax;
    logic [8:0] ay;
    if (en) begin
      side0  <= side_c;
      sweep0 <= sweep;
      for (int l = 0; l < LANES; l++) begin
        ax = vx[l][8] ? 9'(-vx[l]) : 9'(vx[l]);
        ay = vy[l][8] ? 9'(-vy[l]) : 9'(vy[l]);
        x0[l] <= signed'({3'b000, ax, 20'd0});
        y0[l] <= signed'({3'b000, ay, 20'd0});
        axis0[l] <= '{xneg: vx[l][8], yneg: vy[l][8],
                      xzero: vx[l] == '0, yzero: vy[l] == '0};
      end
    end
  end

  logic [CORDIC_STEPS-1:0] vp;
  side_t                   side_p  [CORDIC_STEPS];
  logic [AB-1:0]           sweep_p [CORDIC_STEPS];
  axis_t                   axis_p  [CORDIC_STEPS][LANES];
  logic signed [CW-1:0]    cx [CORDIC_STEPS][LANES];
  logic signed [CW-1:0]    cy [CORDIC_STEPS][LANES];
  logic signed [ZW-1:0]    cz [CORDIC_STEPS][LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else if (en) begin
      vp <= {vp[CORDIC_STEPS-2:0], v0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_p[0]  <= side0;
      sweep_p[0] <= sweep0;
      axis_p[0]  <= axis0;
      for (int s = 1; s < CORDIC_STEPS; s++) begin
        side_p[s]  <= side_p[s-1];
        sweep_p[s] <= sweep_p[s-1];
        axis_p[s]  <= axis_p[s-1];
      end
    end
  end

  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_step
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      if (s == 0) begin : g_first
        rsps_cell #(.STEP(s)) u_cell (
          .clk   (clk),
          .en    (en),
          .x_in  (x0[l]),
          .y_in  (y0[l]),
          .z_in  ('0),
          .x_out (cx[s][l]),
          .y_out (cy[s][l]),
          .z_out (cz[s][l])
        );
      end else begin : g_next
        rsps_cell #(.STEP(s)) u_cell (
          .clk   (clk),
          .en    (en),
          .x_in  (cx[s-1][l]),
          .y_in  (cy[s-1][l]),
          .z_in  (cz[s-1][l]),
          .x_out (cx[s][l]),
          .y_out (cy[s][l]),
          .z_out (cz[s][l])
        );
      end
    end
  end

  rsps_shade #(.ANGLE_BITS(AB)) u_shade (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .valid_in   (vp[CORDIC_STEPS-1]),
    .side_in    (side_p[CORDIC_STEPS-1]),
    .sweep_in   (sweep_p[CORDIC_STEPS-1]),
    .z_in       (cz[CORDIC_STEPS-1]),
    .axis_in    (axis_p[CORDIC_STEPS-1]),
    .valid_out  (m_tvalid),
    .pixel_word (m_tdata),
    .last_out   (m_tlast)
  );

endmodule

// File: rtl/rsps_check.sv
// Port-level checks for the radar sweep pixel shader, bound to the top level.
module rsps_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output space");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_const: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[31:24] == 8'hFF && m_tdata[7:0] == 8'd10)
    else $error("alpha or red byte wrong");

endmodule

bind radar_sweep_pixel_shader rsps_check u_rsps_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
